[hw/rtl/ssm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants for the Smith shadowing-masking term
// Field widths, fixed-point coefficients and pipeline stage numbers.
// ----------------------------------------------------------------------------
package ssm_pkg;

   // field widths
   localparam int VEC_W   = 16;
   localparam int ALPHA_W = 15;
   localparam int G_W     = 16;

   // internal widths
   localparam int SQ_W        = 31;             // x*x, at most 2^30
   localparam int S_W         = 32;             // x*x + y*y
   localparam int ALPHA_SQ_W  = 2 * ALPHA_W;
   localparam int LHS_SHIFT   = 18;
   localparam int LHS_W       = SQ_W + 5 + LHS_SHIFT;
   localparam int RHS_W       = ALPHA_SQ_W + S_W;
   localparam int RAD_SHIFT   = 16;
   localparam int RAD_W       = S_W + RAD_SHIFT;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int SQRT_REM_W  = ROOT_W + 2;
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int DIV_W       = ALPHA_W + ROOT_W;
   localparam int QUO_W       = 17;
   localparam int A_SHIFT     = 36;
   localparam int A2_W        = 2 * QUO_W;
   localparam int COEF_W      = 18;
   localparam int LIN_W       = COEF_W + QUO_W;
   localparam int QUAD_SHIFT  = 16;
   localparam int QUAD_W      = COEF_W + A2_W - QUAD_SHIFT;
   localparam int ND_W        = 37;
   localparam int G_FRAC      = 15;

   // constants
   localparam logic [G_W-1:0]        ONE_Q15        = 16'h8000;
   localparam logic [ND_W-1:0]       DEN_ONE        = 37'h01_0000_0000;
   localparam logic [COEF_W-1:0]     C_A1           = 18'd231670;
   localparam logic [COEF_W-1:0]     C_A2           = 18'd142934;
   localparam logic [COEF_W-1:0]     C_B1           = 18'd149160;
   localparam logic [COEF_W-1:0]     C_B2           = 18'd168886;
   localparam logic [4:0]            SAT_SCALE      = 5'd25;
   localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = 15'd2048;
   localparam logic [ALPHA_SQ_W-1:0] ALPHA_SQ_RESET = 30'd4194304;

   // stage numbers of the direction pipeline
   localparam int SAT_STAGE    = 4;
   localparam int P_SQRT_DONE  = 2 + SQRT_STEPS;
   localparam int P_DIV1_DONE  = P_SQRT_DONE + 1 + QUO_W;
   localparam int P_DIV2_DONE  = P_DIV1_DONE + 3 + QUO_W;
   localparam int G1_LAT       = P_DIV2_DONE + 1;
   localparam int SIDE_STAGE   = 2;
   localparam int OUT_LAT      = G1_LAT + 1;

   typedef struct packed {
      logic [ALPHA_W-1:0]    alpha;
      logic [ALPHA_SQ_W-1:0] alpha_sq;
   } ssm_cfg_type;

endpackage
`default_nettype wire

[hw/rtl/ssm_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_if: request and response channels
// Valid/ready channels carrying the direction triple and the shadowing result.
// ----------------------------------------------------------------------------
interface ssm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ssm_pkg::VEC_W-1:0]    out_x;
   logic signed [ssm_pkg::VEC_W-1:0]    out_y;
   logic signed [ssm_pkg::VEC_W-1:0]    out_z;
   logic signed [ssm_pkg::VEC_W-1:0]    in_x;
   logic signed [ssm_pkg::VEC_W-1:0]    in_y;
   logic signed [ssm_pkg::VEC_W-1:0]    in_z;
   logic signed [ssm_pkg::VEC_W-1:0]    half_x;
   logic signed [ssm_pkg::VEC_W-1:0]    half_y;
   logic signed [ssm_pkg::VEC_W-1:0]    half_z;

   modport source (output valid, out_x, out_y, out_z, in_x, in_y, in_z,
                   half_x, half_y, half_z, input ready);
   modport sink   (input valid, out_x, out_y, out_z, in_x, in_y, in_z,
                   half_x, half_y, half_z, output ready);
endinterface

interface ssm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ssm_pkg::G_W-1:0]     shadow_factor;
   logic                        side_mismatch;

   modport source (output valid, shadow_factor, side_mismatch, input ready);
   modport sink   (input valid, shadow_factor, side_mismatch, output ready);
endinterface
`default_nettype wire

[hw/rtl/ssm_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_div: pipelined restoring divider
// One quotient bit per stage; the start remainder must be below the divisor.
// ----------------------------------------------------------------------------
module ssm_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [ssm_pkg::DIV_W-1:0]   start_rem,
   input  logic [ssm_pkg::QUO_W-1:0]   start_low,
   input  logic [ssm_pkg::DIV_W-1:0]   start_den,
   output logic [ssm_pkg::QUO_W-1:0]   quo
);

   typedef struct packed {
      logic [ssm_pkg::DIV_W-1:0] rem;
      logic [ssm_pkg::QUO_W-1:0] low;
      logic [ssm_pkg::DIV_W-1:0] den;
      logic [ssm_pkg::QUO_W-1:0] quo;
   } div_stage_type;

   function automatic div_stage_type div_step(input div_stage_type p);
      logic [ssm_pkg::DIV_W:0] trial;
      logic                    ge;
      div_stage_type           n;
      trial = {p.rem, p.low[ssm_pkg::QUO_W-1]};
      ge    = trial >= {1'b0, p.den};
      n.rem = ge ? ssm_pkg::DIV_W'(trial - {1'b0, p.den}) : ssm_pkg::DIV_W'(trial);
      n.low = {p.low[ssm_pkg::QUO_W-2:0], 1'b0};
      n.den = p.den;
      n.quo = {p.quo[ssm_pkg::QUO_W-2:0], ge};
      return n;
   endfunction

   div_stage_type start_w;
   div_stage_type next_w  [1:ssm_pkg::QUO_W];
   div_stage_type stage_ff [1:ssm_pkg::QUO_W];

   assign start_w = '{rem: start_rem, low: start_low, den: start_den, quo: '0};

   for (genvar j = 1; j <= ssm_pkg::QUO_W; j++) begin : g_step
      if (j == 1) begin : g_first
         assign next_w[j] = div_step(start_w);
      end else begin : g_rest
         assign next_w[j] = div_step(stage_ff[j-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 1; k <= ssm_pkg::QUO_W; k++) begin
            stage_ff[k] <= next_w[k];
         end
      end
   end

   assign quo = stage_ff[ssm_pkg::QUO_W].quo;

endmodule
`default_nettype wire

[hw/rtl/ssm_g1.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_g1: Beckmann masking term of one direction
// Saturation test, integer square root, a = cos/(alpha*sin), rational fit.
// ----------------------------------------------------------------------------
module ssm_g1 (
   input  logic                               clock,
   input  logic                               en,
   input  ssm_pkg::ssm_cfg_type               cfg,
   input  logic signed [ssm_pkg::VEC_W-1:0]   x,
   input  logic signed [ssm_pkg::VEC_W-1:0]   y,
   input  logic signed [ssm_pkg::VEC_W-1:0]   z,
   output logic [ssm_pkg::G_W-1:0]            g1
);

   localparam int R0_SHIFT = ssm_pkg::A_SHIFT - ssm_pkg::QUO_W;
   localparam int LOW_BITS = ssm_pkg::QUO_W - ssm_pkg::G_FRAC;

   typedef struct packed {
      logic [ssm_pkg::SQRT_REM_W-1:0] rem;
      logic [ssm_pkg::ROOT_W-1:0]     root;
      logic [ssm_pkg::RAD_W-1:0]      rad;
   } sqrt_stage_type;

   function automatic sqrt_stage_type sqrt_step(input sqrt_stage_type p);
      logic [ssm_pkg::SQRT_REM_W+1:0] rem_t;
      logic [ssm_pkg::SQRT_REM_W+1:0] trial;
      logic                           ge;
      sqrt_stage_type                 n;
      rem_t  = {p.rem, p.rad[ssm_pkg::RAD_W-1 -: 2]};
      trial  = (ssm_pkg::SQRT_REM_W+2)'({p.root, 2'b01});
      ge     = rem_t >= trial;
      n.rem  = ge ? ssm_pkg::SQRT_REM_W'(rem_t - trial) : ssm_pkg::SQRT_REM_W'(rem_t);
      n.root = {p.root[ssm_pkg::ROOT_W-2:0], ge};
      n.rad  = {p.rad[ssm_pkg::RAD_W-3:0], 2'b00};
      return n;
   endfunction

   // stage 1
   logic signed [2*ssm_pkg::VEC_W-1:0] x_sq_w, y_sq_w;
   logic [ssm_pkg::VEC_W-1:0]          az_w;
   logic [2*ssm_pkg::VEC_W-1:0]        az_sq_w;
   logic [ssm_pkg::SQ_W-1:0]           xx_ff, yy_ff, azsq_ff;
   logic [ssm_pkg::VEC_W-1:0]          az_ff [1:ssm_pkg::P_SQRT_DONE];

   // stages 2 to 4
   logic [ssm_pkg::SQ_W+4:0]           azsq25_w;
   logic [ssm_pkg::S_W-1:0]            s_ff;
   logic [ssm_pkg::LHS_W-1:0]          lhs_ff, lhs3_ff;
   logic [ssm_pkg::RHS_W-1:0]          rhs_ff;
   logic                               sat_ff [ssm_pkg::SAT_STAGE:ssm_pkg::P_DIV2_DONE];

   // square root
   sqrt_stage_type                     sq_start_w;
   sqrt_stage_type                     sq_next_w [1:ssm_pkg::SQRT_STEPS];
   sqrt_stage_type                     sq_ff     [1:ssm_pkg::SQRT_STEPS];

   // a = |z| * 2^36 / (alpha * s8)
   logic [ssm_pkg::DIV_W-1:0]          d_ff, r0_ff;
   logic [ssm_pkg::QUO_W-1:0]          a_w;

   // rational fit
   logic [ssm_pkg::A2_W-1:0]           a2_ff;
   logic [ssm_pkg::LIN_W-1:0]          ca1_ff, cb1_ff, ca1b_ff, cb1b_ff;
   logic [ssm_pkg::COEF_W+ssm_pkg::A2_W-1:0] pa_w, pb_w;
   logic [ssm_pkg::QUAD_W-1:0]         ca2_ff, cb2_ff;
   logic [ssm_pkg::ND_W-1:0]           num_ff, den_ff;
   logic [ssm_pkg::QUO_W-1:0]          q2_w;
   logic [ssm_pkg::G_W-1:0]            g1_ff;

   assign x_sq_w  = x * x;
   assign y_sq_w  = y * y;
   assign az_w    = z[ssm_pkg::VEC_W-1] ? ssm_pkg::VEC_W'($unsigned(-z))
                                        : ssm_pkg::VEC_W'($unsigned(z));
   assign az_sq_w = az_w * az_w;
   assign azsq25_w = (ssm_pkg::SQ_W+5)'(azsq_ff) * (ssm_pkg::SQ_W+5)'(ssm_pkg::SAT_SCALE);

   assign sq_start_w = '{rem: '0, root: '0, rad: {s_ff, ssm_pkg::RAD_SHIFT'(0)}};

   for (genvar j = 1; j <= ssm_pkg::SQRT_STEPS; j++) begin : g_sqrt
      if (j == 1) begin : g_first
         assign sq_next_w[j] = sqrt_step(sq_start_w);
      end else begin : g_rest
         assign sq_next_w[j] = sqrt_step(sq_ff[j-1]);
      end
   end

   assign pa_w = (ssm_pkg::COEF_W+ssm_pkg::A2_W)'(ssm_pkg::C_A2)
               * (ssm_pkg::COEF_W+ssm_pkg::A2_W)'(a2_ff);
   assign pb_w = (ssm_pkg::COEF_W+ssm_pkg::A2_W)'(ssm_pkg::C_B2)
               * (ssm_pkg::COEF_W+ssm_pkg::A2_W)'(a2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff    <= x_sq_w[ssm_pkg::SQ_W-1:0];
         yy_ff    <= y_sq_w[ssm_pkg::SQ_W-1:0];
         azsq_ff  <= az_sq_w[ssm_pkg::SQ_W-1:0];
         az_ff[1] <= az_w;
         for (int k = 2; k <= ssm_pkg::P_SQRT_DONE; k++) begin
            az_ff[k] <= az_ff[k-1];
         end

         s_ff    <= ssm_pkg::S_W'(xx_ff) + ssm_pkg::S_W'(yy_ff);
         lhs_ff  <= {azsq25_w, ssm_pkg::LHS_SHIFT'(0)};
         rhs_ff  <= ssm_pkg::RHS_W'(cfg.alpha_sq) * ssm_pkg::RHS_W'(s_ff);
         lhs3_ff <= lhs_ff;

         // a of 1.6 or more, or no sine at all: the term is one
         sat_ff[ssm_pkg::SAT_STAGE] <= ssm_pkg::RHS_W'(lhs3_ff) >= rhs_ff;
         for (int k = ssm_pkg::SAT_STAGE + 1; k <= ssm_pkg::P_DIV2_DONE; k++) begin
            sat_ff[k] <= sat_ff[k-1];
         end

         for (int k = 1; k <= ssm_pkg::SQRT_STEPS; k++) begin
            sq_ff[k] <= sq_next_w[k];
         end

         d_ff  <= ssm_pkg::DIV_W'(cfg.alpha) * ssm_pkg::DIV_W'(sq_ff[ssm_pkg::SQRT_STEPS].root);
         // low dividend bits are all zero, so the division starts at |z| << 19
         r0_ff <= ssm_pkg::DIV_W'({az_ff[ssm_pkg::P_SQRT_DONE], R0_SHIFT'(0)});

         a2_ff  <= ssm_pkg::A2_W'(a_w) * ssm_pkg::A2_W'(a_w);
         ca1_ff <= ssm_pkg::LIN_W'(ssm_pkg::C_A1) * ssm_pkg::LIN_W'(a_w);
         cb1_ff <= ssm_pkg::LIN_W'(ssm_pkg::C_B1) * ssm_pkg::LIN_W'(a_w);

         ca2_ff  <= pa_w[ssm_pkg::COEF_W+ssm_pkg::A2_W-1:ssm_pkg::QUAD_SHIFT];
         cb2_ff  <= pb_w[ssm_pkg::COEF_W+ssm_pkg::A2_W-1:ssm_pkg::QUAD_SHIFT];
         ca1b_ff <= ca1_ff;
         cb1b_ff <= cb1_ff;

         num_ff <= ssm_pkg::ND_W'(ca1b_ff) + ssm_pkg::ND_W'(ca2_ff);
         den_ff <= ssm_pkg::DEN_ONE + ssm_pkg::ND_W'(cb1b_ff) + ssm_pkg::ND_W'(cb2_ff);

         if (sat_ff[ssm_pkg::P_DIV2_DONE] || q2_w > ssm_pkg::QUO_W'(ssm_pkg::ONE_Q15)) begin
            g1_ff <= ssm_pkg::ONE_Q15;
         end else begin
            g1_ff <= q2_w[ssm_pkg::G_W-1:0];
         end
      end
   end

   ssm_div u_div_slope (
      .clock     (clock),
      .en        (en),
      .start_rem (r0_ff),
      .start_low ('0),
      .start_den (d_ff),
      .quo       (a_w)
   );

   // num * 2^15 / den: top part as start remainder, two num bits shifted in
   ssm_div u_div_ratio (
      .clock     (clock),
      .en        (en),
      .start_rem (ssm_pkg::DIV_W'(num_ff[ssm_pkg::ND_W-1:LOW_BITS])),
      .start_low ({num_ff[LOW_BITS-1:0], ssm_pkg::G_FRAC'(0)}),
      .start_den (ssm_pkg::DIV_W'(den_ff)),
      .quo       (q2_w)
   );

   assign g1 = g1_ff;

endmodule
`default_nettype wire

[hw/rtl/smith_shadowing_masking_term.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smith_shadowing_masking_term: Beckmann Smith shadowing-masking factor
// Side test against the half vector and the product of two masking terms.
// ----------------------------------------------------------------------------
// One request enters per cycle unless stalled; its response passes the
// per-direction pipeline, a 24-stage square root and two 17-stage dividers,
// with both directions worked on side by side. When the response is not
// taken the whole pipeline holds and no request is taken. Write roughness
// alpha through the csr port only while no request is in flight; the block
// does not enforce it. Its square is formed in the register write.
module smith_shadowing_masking_term (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [ssm_pkg::ALPHA_W-1:0]   csr_wr_data,
   ssm_req_if.sink                       req_ch,
   ssm_rsp_if.source                     rsp_ch
);

   localparam int P_W = 2 * ssm_pkg::VEC_W;
   localparam int DOT_W = P_W + 2;

   ssm_pkg::ssm_cfg_type        cfg_ff;
   logic                        en_w;
   logic                        vld_ff [1:ssm_pkg::OUT_LAT];

   logic signed [P_W-1:0]       pox_ff, poy_ff, poz_ff, pix_ff, piy_ff, piz_ff;
   logic                        oz_neg_ff, oz_zero_ff, iz_neg_ff, iz_zero_ff;
   logic signed [DOT_W-1:0]     dot_o_w, dot_i_w;
   logic                        mis_w;
   logic                        mis_ff [ssm_pkg::SIDE_STAGE:ssm_pkg::G1_LAT];

   logic [ssm_pkg::G_W-1:0]     g_in_w, g_out_w;
   logic [2*ssm_pkg::G_W-1:0]   prod_w;
   logic [ssm_pkg::G_W-1:0]     factor_ff;
   logic                        mismatch_ff;

   // whole pipeline advances unless a finished response is held
   assign en_w = !vld_ff[ssm_pkg::OUT_LAT] || rsp_ch.ready;
   assign req_ch.ready = en_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha    <= ssm_pkg::ALPHA_RESET;
         cfg_ff.alpha_sq <= ssm_pkg::ALPHA_SQ_RESET;
      end else if (csr_wr_en) begin
         cfg_ff.alpha    <= csr_wr_data;
         cfg_ff.alpha_sq <= ssm_pkg::ALPHA_SQ_W'(csr_wr_data) * ssm_pkg::ALPHA_SQ_W'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= ssm_pkg::OUT_LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en_w) begin
         vld_ff[1] <= req_ch.valid;
         for (int k = 2; k <= ssm_pkg::OUT_LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // side test: sign of dot with the half vector against sign of z
   assign dot_o_w = DOT_W'(pox_ff) + DOT_W'(poy_ff) + DOT_W'(poz_ff);
   assign dot_i_w = DOT_W'(pix_ff) + DOT_W'(piy_ff) + DOT_W'(piz_ff);
   assign mis_w = (dot_o_w[DOT_W-1] != oz_neg_ff) || ((dot_o_w == '0) != oz_zero_ff)
               || (dot_i_w[DOT_W-1] != iz_neg_ff) || ((dot_i_w == '0) != iz_zero_ff);

   assign prod_w = g_in_w * g_out_w;

   always_ff @(posedge clock) begin
      if (en_w) begin
         pox_ff     <= req_ch.out_x * req_ch.half_x;
         poy_ff     <= req_ch.out_y * req_ch.half_y;
         poz_ff     <= req_ch.out_z * req_ch.half_z;
         pix_ff     <= req_ch.in_x * req_ch.half_x;
         piy_ff     <= req_ch.in_y * req_ch.half_y;
         piz_ff     <= req_ch.in_z * req_ch.half_z;
         oz_neg_ff  <= req_ch.out_z[ssm_pkg::VEC_W-1];
         oz_zero_ff <= req_ch.out_z == '0;
         iz_neg_ff  <= req_ch.in_z[ssm_pkg::VEC_W-1];
         iz_zero_ff <= req_ch.in_z == '0;

         mis_ff[ssm_pkg::SIDE_STAGE] <= mis_w;
         for (int k = ssm_pkg::SIDE_STAGE + 1; k <= ssm_pkg::G1_LAT; k++) begin
            mis_ff[k] <= mis_ff[k-1];
         end

         mismatch_ff <= mis_ff[ssm_pkg::G1_LAT];
         if (mis_ff[ssm_pkg::G1_LAT]) begin
            factor_ff <= '0;
         end else begin
            factor_ff <= prod_w[ssm_pkg::G_W+ssm_pkg::G_FRAC-1:ssm_pkg::G_FRAC];
         end
      end
   end

   ssm_g1 u_g1_in (
      .clock (clock),
      .en    (en_w),
      .cfg   (cfg_ff),
      .x     (req_ch.in_x),
      .y     (req_ch.in_y),
      .z     (req_ch.in_z),
      .g1    (g_in_w)
   );

   ssm_g1 u_g1_out (
      .clock (clock),
      .en    (en_w),
      .cfg   (cfg_ff),
      .x     (req_ch.out_x),
      .y     (req_ch.out_y),
      .z     (req_ch.out_z),
      .g1    (g_out_w)
   );

   assign rsp_ch.valid         = vld_ff[ssm_pkg::OUT_LAT];
   assign rsp_ch.shadow_factor = factor_ff;
   assign rsp_ch.side_mismatch = mismatch_ff;

endmodule
`default_nettype wire

[dv/ssm_checker.sv]
// ----------------------------------------------------------------------------
// ssm_checker: response checker for the Smith shadowing-masking term
// Watches the request and response channels and the csr write port, predicts
// the shadowing factor of each accepted request and compares in order.
// ----------------------------------------------------------------------------
module ssm_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [ssm_pkg::ALPHA_W-1:0] csr_wr_data,
   ssm_req_if                          req_ch,
   ssm_rsp_if                          rsp_ch,
   output int                          fail_count,
   output int                          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [ssm_pkg::G_W-1:0] shadow_factor;
      logic                    side_mismatch;
   } shade_result_type;

   logic [ssm_pkg::ALPHA_W-1:0] alpha_shadow;
   shade_result_type            expected_shading[$];

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned beckmann_g1(longint x, longint y, longint z);
      longint unsigned s2, az, al, lhs, rhs, s8, a, a2, num, den, g;
      s2 = longint'(x * x) + longint'(y * y);
      az = (z < 0) ? -z : z;
      al = alpha_shadow;
      lhs = 64'd25 * (64'd1 << 18) * az * az;
      rhs = al * al * s2;
      if (lhs >= rhs) return 64'd32768;
      s8 = int_sqrt(s2 << 16);
      a = (az << 36) / (al * s8);
      a2 = a * a;
      num = 64'd231670 * a + ((64'd142934 * a2) >> 16);
      den = (64'd1 << 32) + 64'd149160 * a + ((64'd168886 * a2) >> 16);
      g = (num << 15) / den;
      return (g > 64'd32768) ? 64'd32768 : g;
   endfunction

   function automatic int sgn(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic shade_result_type predict_shading();
      shade_result_type r;
      longint ox, oy, oz, ix, iy, iz, hx, hy, hz, dot_o, dot_i;
      ox = req_ch.out_x;  oy = req_ch.out_y;  oz = req_ch.out_z;
      ix = req_ch.in_x;   iy = req_ch.in_y;   iz = req_ch.in_z;
      hx = req_ch.half_x; hy = req_ch.half_y; hz = req_ch.half_z;
      dot_o = ox * hx + oy * hy + oz * hz;
      dot_i = ix * hx + iy * hy + iz * hz;
      if (sgn(dot_o) != sgn(oz) || sgn(dot_i) != sgn(iz)) begin
         r.shadow_factor = '0;
         r.side_mismatch = 1'b1;
      end else begin
         r.shadow_factor = ssm_pkg::G_W'((beckmann_g1(ix, iy, iz)
                                          * beckmann_g1(ox, oy, oz)) >> 15);
         r.side_mismatch = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      shade_result_type want;
      if (reset) begin
         alpha_shadow <= ssm_pkg::ALPHA_RESET;
      end else begin
         if (csr_wr_en) alpha_shadow <= csr_wr_data;
         if (req_ch.valid && req_ch.ready) expected_shading.push_back(predict_shading());
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_shading.size() == 0) begin
               report_mismatch("response with no request waiting");
            end else begin
               want = expected_shading.pop_front();
               if (rsp_ch.shadow_factor !== want.shadow_factor)
                  report_mismatch($sformatf("shadow_factor got %0d want %0d",
                                            rsp_ch.shadow_factor, want.shadow_factor));
               if (rsp_ch.side_mismatch !== want.side_mismatch)
                  report_mismatch($sformatf("side_mismatch got %0b want %0b",
                                            rsp_ch.side_mismatch, want.side_mismatch));
            end
         end
      end
      pending_count = expected_shading.size();
   end
endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression for the Smith shadowing-masking term
// Directed corner requests then random direction triples over several alpha
// settings and idling phases, with a long response hold-off to fill the pipe.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = ssm_pkg::OUT_LAT + 20;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wr_en = 1'b0;
   logic [ssm_pkg::ALPHA_W-1:0] csr_wr_data = '0;
   int                          fail_count, pending_count;
   int                          send_idle_pct = 0, recv_stall_pct = 0;
   bit                          hold_off = 1'b0;

   ssm_req_if req_ch();
   ssm_rsp_if rsp_ch();

   smith_shadowing_masking_term dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   ssm_checker chk (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_ch(req_ch), .rsp_ch(rsp_ch), .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      {req_ch.out_x, req_ch.out_y, req_ch.out_z} = '0;
      {req_ch.in_x, req_ch.in_y, req_ch.in_z} = '0;
      {req_ch.half_x, req_ch.half_y, req_ch.half_z} = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || hold_off) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // one request; fields in order out, in, half
   task automatic send_request(input logic [15:0] f [9]);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.out_x  <= f[0]; req_ch.out_y  <= f[1]; req_ch.out_z  <= f[2];
      req_ch.in_x   <= f[3]; req_ch.in_y   <= f[4]; req_ch.in_z   <= f[5];
      req_ch.half_x <= f[6]; req_ch.half_y <= f[7]; req_ch.half_z <= f[8];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_alpha(input logic [ssm_pkg::ALPHA_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_pipe();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_comp(int mag);
      int v;
      v = $urandom_range(mag);
      return ($urandom_range(1) != 0) ? 16'(-v) : 16'(v);
   endfunction

   // mostly roughly consistent triples so the masking terms get exercised
   task automatic send_random();
      logic [15:0] f [9];
      int k;
      k = $urandom_range(9);
      if (k == 0) begin
         foreach (f[i]) f[i] = 16'($urandom);
      end else begin
         f[0] = rand_comp(32767); f[1] = rand_comp(32767);
         f[2] = 16'($urandom_range(32767));
         f[3] = rand_comp(32767); f[4] = rand_comp(32767);
         f[5] = 16'($urandom_range(32767));
         if (k < 3) begin
            f[2] = rand_comp(2000);
            f[5] = rand_comp(32767);
         end
         f[6] = rand_comp(8000); f[7] = rand_comp(8000);
         f[8] = 16'($urandom_range(32767, 16000));
      end
      send_request(f);
   endtask

   initial begin
      logic [15:0] d [9];
      logic [15:0] ext [4];
      logic [ssm_pkg::ALPHA_W-1:0] alphas [6];
      ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
      alphas = '{15'd1, 15'd16384, 15'd2048, 15'h7FFF, 15'd300, 15'd0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: normal incidence, grazing, side failures, sign extremes
      d = '{16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF,
            16'h0000, 16'h0000, 16'h7FFF}; send_request(d);
      d = '{16'h7FFF, 16'h0000, 16'h0001, 16'h0000, 16'h7FFF, 16'h0001,
            16'h0000, 16'h0000, 16'h7FFF}; send_request(d);
      d = '{16'h5A82, 16'h0000, 16'h5A82, 16'h0000, 16'hA57E, 16'h5A82,
            16'h0000, 16'h0000, 16'h7FFF}; send_request(d);
      d = '{16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h8001,
            16'h0000, 16'h0000, 16'h7FFF}; send_request(d);
      d = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 16'h0000, 16'h0000}; send_request(d);
      d = '{16'h7FFF, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h7FFF,
            16'h8000, 16'h0000, 16'h0001}; send_request(d);
      d = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 16'h8000, 16'h8000}; send_request(d);
      for (int i = 0; i < 16; i++) begin
         foreach (d[j]) d[j] = ext[$urandom_range(3)];
         send_request(d);
      end
      drain_pipe();

      // idling phases against alpha settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         write_alpha(alphas[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         if (ph == 2) begin
            // long response hold-off while requests keep coming
            fork
               begin
                  hold_off = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_off = 1'b0;
               end
               repeat (120) send_random();
            join
         end
         repeat (310) send_random();
         drain_pipe();
      end

      if (fail_count == 0) $display("smith_shadowing_masking_term regression: pass");
      else $display("smith_shadowing_masking_term regression: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("smith_shadowing_masking_term regression: fail");
      $finish;
   end
endmodule

[files.f]
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_if.sv
hw/rtl/ssm_div.sv
hw/rtl/ssm_g1.sv
hw/rtl/smith_shadowing_masking_term.sv
dv/ssm_checker.sv
dv/tb.sv
